/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and codes for the sorted priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  localparam int VALUE_W = 16;
  localparam int PRIO_W  = 32;
  localparam int COUNT_W = 7;
  localparam int STAT_W  = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
  } spq_entry_t;

endpackage

/* sv/spq_ram.sv */
// ----------------------------------------------------------------------------
// spq_ram
// entry storage: one write port, one read port with registered data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_ram
  import spq_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  spq_entry_t    wdata,
  input  logic [AW-1:0] raddr,
  output spq_entry_t    rdata
);

  spq_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded min-priority queue kept sorted in a ring buffer memory
// ----------------------------------------------------------------------------
// the registered result strobe comes in the cycle after the last working cycle of
// a transaction; refusals and inserts into an empty queue end in the start cycle;
// a remove returns the head; an insert moves each entry of greater priority up
// one slot, one memory read and one write per cycle, then writes the new entry
// throughput: one transaction in flight; start is taken again in the strobe cycle
// reset (synchronous, active low) empties the queue; stored entries are not cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic [VALUE_W-1:0] in_item_value,
  input  logic [PRIO_W-1:0]  in_item_priority,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [VALUE_W-1:0] out_removed_value,
  output logic [COUNT_W-1:0] out_entry_count
);

  localparam int AW    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_INS   = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;
  localparam logic [1:0] S_RM    = 2'd3;

  function automatic logic [AW-1:0] next_addr(input logic [AW-1:0] a);
    next_addr = (a == AW'(QUEUE_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] prev_addr(input logic [AW-1:0] a);
    prev_addr = (a == '0) ? AW'(QUEUE_DEPTH - 1) : a - 1'b1;
  endfunction

  logic [1:0]         state_r, state_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]      ra_r, ra_nxt;
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [CNT_W-1:0]   left_r, left_nxt;
  spq_entry_t         new_r, new_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  spq_entry_t         ram_wdata;
  logic [AW-1:0]      ram_raddr;
  spq_entry_t         ram_rdata;
  logic [AW-1:0]      tail_prev;
  spq_entry_t         in_entry;

  assign tail_prev = prev_addr(tail_r);
  assign in_entry  = '{value: in_item_value, prio: in_item_priority};

  spq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    ra_nxt         = ra_r;
    wp_nxt         = wp_r;
    left_nxt       = left_r;
    new_nxt        = new_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = wp_r;
    ram_wdata      = new_r;
    ram_raddr      = ra_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_value_nxt = '0;
          if (in_opcode == OP_INSERT) begin
            if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_FULL;
              out_count_nxt  = COUNT_W'(cnt_r);
            end else if (cnt_r == '0) begin
              ram_we         = 1'b1;
              ram_waddr      = tail_r;
              ram_wdata      = in_entry;
              tail_nxt       = next_addr(tail_r);
              cnt_nxt        = cnt_r + 1'b1;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_DONE;
              out_count_nxt  = COUNT_W'(cnt_r + 1'b1);
            end else begin
              ram_raddr = tail_prev;
              ra_nxt    = prev_addr(tail_prev);
              wp_nxt    = tail_r;
              left_nxt  = cnt_r;
              new_nxt   = in_entry;
              state_nxt = S_INS;
            end
          end else begin
            if (cnt_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_EMPTY;
              out_count_nxt  = COUNT_W'(cnt_r);
            end else begin
              ram_raddr = head_r;
              state_nxt = S_RM;
            end
          end
        end
      end
      S_INS: begin
        if (ram_rdata.prio > new_r.prio) begin
          ram_we    = 1'b1;
          ram_waddr = wp_r;
          ram_wdata = ram_rdata;
          wp_nxt    = prev_addr(wp_r);
          left_nxt  = left_r - 1'b1;
          ra_nxt    = prev_addr(ra_r);
          if (left_r == CNT_W'(1)) begin
            state_nxt = S_PLACE;
          end
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = wp_r;
          ram_wdata      = new_r;
          tail_nxt       = next_addr(tail_r);
          cnt_nxt        = cnt_r + 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DONE;
          out_count_nxt  = COUNT_W'(cnt_r + 1'b1);
          state_nxt      = S_IDLE;
        end
      end
      S_PLACE: begin
        ram_we         = 1'b1;
        ram_waddr      = wp_r;
        ram_wdata      = new_r;
        tail_nxt       = next_addr(tail_r);
        cnt_nxt        = cnt_r + 1'b1;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DONE;
        out_count_nxt  = COUNT_W'(cnt_r + 1'b1);
        state_nxt      = S_IDLE;
      end
      S_RM: begin
        head_nxt       = next_addr(head_r);
        cnt_nxt        = cnt_r - 1'b1;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DONE;
        out_value_nxt  = ram_rdata.value;
        out_count_nxt  = COUNT_W'(cnt_r - 1'b1);
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ra_r         <= ra_nxt;
    wp_r         <= wp_nxt;
    left_r       <= left_nxt;
    new_r        <= new_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_value_r;
  assign out_entry_count   = out_count_r;

endmodule

/* sv/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// port-level checks for the sorted priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_checker
  import spq_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input logic [STAT_W-1:0]  out_status,
  input logic [VALUE_W-1:0] out_removed_value,
  input logic [COUNT_W-1:0] out_entry_count
);

  // a result always closes its transaction
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !busy)
    else $error("result shown while still busy");

  // every result carries one of the defined status codes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_FULL ||
                   out_status == ST_EMPTY))
    else $error("result status out of range");

  // refused transactions return no value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_removed_value == '0)
    else $error("refused transaction returned a value");

  // empty refusal reports an empty queue
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entry_count == '0)
    else $error("empty refusal with nonzero count");

  // reset leaves the block idle with no result pending
  assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_removed_value (out_removed_value),
  .out_entry_count   (out_entry_count)
);

/* tb/tb_sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// The testbench drives insert and remove commands into the sorted priority
// queue. Directed commands come first, then random phases that fill, drain or
// mix. A behavioral copy of the sorted list predicts status, removed value
// and entry count. The monitor checks each one-cycle result strobe, in order,
// against those predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int RAND_ITEMS = 950;

  typedef struct {
    logic               op;
    logic [VALUE_W-1:0] value;
    logic [PRIO_W-1:0]  prio;
    int                 gap;
    bit                 drain;
  } cmd_t;

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic [VALUE_W-1:0] removed;
    logic [COUNT_W-1:0] count;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_opcode = OP_INSERT;
  logic [VALUE_W-1:0] in_item_value = '0;
  logic [PRIO_W-1:0]  in_item_priority = '0;
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [VALUE_W-1:0] out_removed_value;
  logic [COUNT_W-1:0] out_entry_count;

  cmd_t   cmd_q[$];
  reply_t reply_q[$];
  cmd_t   cur_cmd;
  int     gap_left = 0;
  int     sent_cnt = 0;
  int     got_cnt = 0;
  int     errors = 0;
  bit     no_idle = 1'b0;

  logic [VALUE_W-1:0] mdl_value[DEPTH];
  logic [PRIO_W-1:0]  mdl_prio[DEPTH];
  int                 mdl_count = 0;

  sorted_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_entry_count  (out_entry_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb_sorted_priority_queue: done, errors");
    $finish;
  end

  // apply one transaction to the sorted list and queue its reply
  task automatic sorted_list_update(input cmd_t c);
    reply_t r;
    int     pos;
    r.status  = ST_DONE;
    r.removed = '0;
    if (c.op == OP_INSERT) begin
      if (mdl_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < mdl_count && mdl_prio[pos] <= c.prio) pos++;
        for (int k = mdl_count; k > pos; k--) begin
          mdl_value[k] = mdl_value[k-1];
          mdl_prio[k]  = mdl_prio[k-1];
        end
        mdl_value[pos] = c.value;
        mdl_prio[pos]  = c.prio;
        mdl_count++;
      end
    end else begin
      if (mdl_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed = mdl_value[0];
        for (int k = 1; k < mdl_count; k++) begin
          mdl_value[k-1] = mdl_value[k];
          mdl_prio[k-1]  = mdl_prio[k];
        end
        mdl_count--;
      end
    end
    r.count = mdl_count[COUNT_W-1:0];
    reply_q.push_back(r);
  endtask

  task automatic add_cmd(input logic op, input logic [VALUE_W-1:0] value,
                         input logic [PRIO_W-1:0] prio, input bit drain);
    cmd_t c;
    c.op    = op;
    c.value = value;
    c.prio  = prio;
    c.gap   = no_idle ? 0 : $urandom_range(0, 7);
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  function automatic logic [PRIO_W-1:0] rand_prio();
    logic [PRIO_W-1:0] p;
    case ($urandom_range(0, 4))
      0: p = $urandom_range(0, 3);
      1: p = {16'($urandom_range(0, 15)), 16'h0000};
      2: begin
        case ($urandom_range(0, 2))
          0: p = '0;
          1: p = '1;
          default: p = 32'h0001_0000;
        endcase
      end
      default: p = $urandom;
    endcase
    return p;
  endfunction

  // driver
  always @(posedge clk) begin : drv
    bit go;
    go = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        sorted_list_update(cur_cmd);
        sent_cnt++;
      end
      if (!(start && busy)) begin
        if (cmd_q.size() > 0) begin
          if (cmd_q[0].drain && sent_cnt != got_cnt) go = 1'b0;
          else if (gap_left > 0) gap_left--;
          else go = 1'b1;
        end
        if (go) begin
          cur_cmd = cmd_q.pop_front();
          in_opcode        <= cur_cmd.op;
          in_item_value    <= cur_cmd.value;
          in_item_priority <= cur_cmd.prio;
          start            <= 1'b1;
          gap_left = (cmd_q.size() > 0) ? cmd_q[0].gap : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    reply_t r;
    if (rst_n && out_valid) begin
      got_cnt <= got_cnt + 1;
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected result status %0d value %h count %0d", $time,
                 out_status, out_removed_value, out_entry_count);
        errors++;
      end else begin
        r = reply_q.pop_front();
        if (out_status !== r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, r.status, out_status);
          errors++;
        end
        if (out_removed_value !== r.removed) begin
          $display("%0t: removed_value expected %h actual %h", $time, r.removed,
                   out_removed_value);
          errors++;
        end
        if (out_entry_count !== r.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, r.count,
                   out_entry_count);
          errors++;
        end
      end
    end
  end

  initial begin : main
    int   n_rand;
    int   mode;
    int   len;
    bit   drain;
    logic op;

    // directed: empty remove, field extremes, ties at both ends and in the middle
    add_cmd(OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_cmd(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    add_cmd(OP_INSERT, 16'h0000, 32'h0000_0000, 1'b0);
    add_cmd(OP_INSERT, 16'h1234, 32'h0001_0000, 1'b0);
    add_cmd(OP_INSERT, 16'h000A, 32'h0001_0000, 1'b0);
    add_cmd(OP_INSERT, 16'h000B, 32'h0001_0000, 1'b0);
    add_cmd(OP_INSERT, 16'h000C, 32'h0001_0000, 1'b0);
    add_cmd(OP_INSERT, 16'h5555, 32'hFFFF_FFFF, 1'b0);
    add_cmd(OP_INSERT, 16'hAAAA, 32'h0000_0000, 1'b0);
    for (int k = 0; k < 9; k++) add_cmd(OP_REMOVE, 16'h0000, 32'h0000_0000, 1'b0);
    add_cmd(OP_REMOVE, 16'h0000, 32'h0000_0000, 1'b0);
    add_cmd(OP_INSERT, 16'h0000, 32'h7FFF_FFFF, 1'b1);
    add_cmd(OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);

    // random phases: mixed, fill-heavy, drain-heavy, fill past full, drain past empty
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      mode    = $urandom_range(0, 4);
      len     = (mode >= 3) ? 70 : $urandom_range(20, 80);
      no_idle = ($urandom_range(0, 3) == 0);
      drain   = (n_rand == 0) || ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        case (mode)
          0: op = $urandom_range(0, 1) ? OP_REMOVE : OP_INSERT;
          1: op = ($urandom_range(0, 99) < 85) ? OP_INSERT : OP_REMOVE;
          2: op = ($urandom_range(0, 99) < 85) ? OP_REMOVE : OP_INSERT;
          3: op = OP_INSERT;
          default: op = OP_REMOVE;
        endcase
        add_cmd(op, 16'($urandom), rand_prio(), drain && (k == 0));
        n_rand++;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() > 0 || start) @(posedge clk);
    while (reply_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (errors == 0) begin
      $display("tb_sorted_priority_queue: done, clean");
    end else begin
      $display("tb_sorted_priority_queue: done, errors");
    end
    $finish;
  end

endmodule
